@@ design/mtpu_pkg.sv @@
// Shared constants for the mex tracker with point updates.
`default_nettype none

package mtpu_pkg;

   localparam int POSITION_W      = 10;
   localparam int VALUE_W         = 30;
   localparam int MEX_W           = 11;
   localparam int COUNT_W         = 11;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;
   localparam int ENTRIES_DEFAULT = 1024;
   localparam int TRACKED_DEFAULT = 2048;
   localparam int MAP_WORD_LOG2   = 6;

endpackage

`default_nettype wire

@@ design/mex_tracker_with_point_update_core.sv @@
// Mex tracker: entry, count and absent-bitmap memories with a two-level mex search.
//
// Each beat overwrites one position and returns the smallest tracked value
// that no position holds, or raises all_present with mex zero when every
// tracked value is present. The result is registered in the last of the
// steps below, and the next beat can be accepted once it is registered. The
// steps are: the accepting cycle with the old entry read, the count read of
// the old value, the decrement writeback, the increment writeback, the
// search of the word summary with the bitmap word read, and the encode of
// that word. While an earlier result still waits, the block holds in the
// encode step. The count and bitmap memories each have one read and one
// write port, and the steps follow their read-modify-write sequence. After
// reset a clearing pass runs over the entry, count and bitmap memories
// before the first beat is accepted. A position at or above ENTRIES changes
// nothing.
`default_nettype none

module mex_tracker_with_point_update_core #(
   parameter int ENTRIES = mtpu_pkg::ENTRIES_DEFAULT,
   parameter int TRACKED = mtpu_pkg::TRACKED_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [mtpu_pkg::POSITION_W-1:0] req_position,
   input  wire logic [mtpu_pkg::VALUE_W-1:0]    req_new_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [mtpu_pkg::MEX_W-1:0]      rsp_mex,
   output logic                                rsp_all_present
);

   localparam int EA        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int TA        = $clog2(TRACKED);
   localparam int WL        = (TA < mtpu_pkg::MAP_WORD_LOG2) ? TA : mtpu_pkg::MAP_WORD_LOG2;
   localparam int W         = 1 << WL;
   localparam int NW        = (TRACKED + W - 1) / W;
   localparam int NA        = (NW > 1) ? $clog2(NW) : 1;
   localparam int LAST_BITS = TRACKED - (NW - 1) * W;
   localparam int CLR       = (ENTRIES > TRACKED) ? ENTRIES : TRACKED;
   localparam int CW        = $clog2(CLR);
   localparam int VW        = mtpu_pkg::VALUE_W;
   localparam int KW        = mtpu_pkg::COUNT_W;
   localparam int MW        = mtpu_pkg::MEX_W;
   localparam logic [W-1:0]  LAST_MASK = {W{1'b1}} >> (W - LAST_BITS);
   localparam logic [VW-1:0] UNTRACKED = {VW{1'b1}};

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_OLD   = 3'd2;
   localparam logic [2:0] ST_DEC   = 3'd3;
   localparam logic [2:0] ST_INC   = 3'd4;
   localparam logic [2:0] ST_FIND  = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [NW-1:0] summary_ff, summary_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [mtpu_pkg::MEX_W-1:0] rsp_mex_ff, rsp_mex_in;
   logic          rsp_all_ff, rsp_all_in;

   logic [EA-1:0] pos_ff, pos_in;
   logic          pos_ok_ff, pos_ok_in;
   logic [VW-1:0] nv_ff, nv_in;
   logic          nv_trk_ff, nv_trk_in;
   logic [TA-1:0] ov_ff, ov_in;
   logic          ov_trk_ff, ov_trk_in;
   logic [KW-1:0] dec_ff, dec_in;
   logic [W-1:0]  wdec_ff, wdec_in;
   logic [NA-1:0] fw_ff, fw_in;
   logic          found_ff, found_in;

   logic          ent_we, ent_re;
   logic [EA-1:0] ent_wa, ent_ra;
   logic [VW-1:0] ent_wd, ent_rdata;
   logic          cnt_we, cnt_re;
   logic [TA-1:0] cnt_wa, cnt_ra;
   logic [KW-1:0] cnt_wd, cnt_rdata;
   logic          map_we, map_re;
   logic [NA-1:0] map_wa, map_ra;
   logic [W-1:0]  map_wd, map_rdata;

   logic          req_fire, out_free, clr_last;
   logic [TA-1:0] ov_t, nv_t;
   logic [NA-1:0] wo, wn, fw_sel;
   logic [KW-1:0] cnt_cur, cnt_inc;
   logic [W-1:0]  word_cur, word_inc;
   logic [WL-1:0] fb;
   logic [TA-1:0] mex_full;

   mtpu_ram #(.WIDTH(VW), .DEPTH(ENTRIES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_wa),
      .wr_data (ent_wd),
      .rd_en   (ent_re),
      .rd_addr (ent_ra),
      .rd_data (ent_rdata)
   );

   mtpu_ram #(.WIDTH(KW), .DEPTH(TRACKED)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_wa),
      .wr_data (cnt_wd),
      .rd_en   (cnt_re),
      .rd_addr (cnt_ra),
      .rd_data (cnt_rdata)
   );

   mtpu_ram #(.WIDTH(W), .DEPTH(NW)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wa),
      .wr_data (map_wd),
      .rd_en   (map_re),
      .rd_addr (map_ra),
      .rd_data (map_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign clr_last  = (clr_ff == CW'(CLR - 1));

   assign ov_t = TA'(ent_rdata);
   assign nv_t = TA'(nv_ff);
   assign wo   = NA'(ov_ff >> WL);
   assign wn   = NA'(nv_t >> WL);

   assign cnt_cur  = (ov_trk_ff && (ov_ff == nv_t)) ? dec_ff : cnt_rdata;
   assign cnt_inc  = (cnt_cur < mtpu_pkg::COUNT_MAX) ? cnt_cur + KW'(1) : cnt_cur;
   assign word_cur = (ov_trk_ff && (wo == wn)) ? wdec_ff : map_rdata;

   always_comb begin
      word_inc = word_cur;
      word_inc[nv_t[WL-1:0]] = 1'b0;
   end

   always_comb begin
      dec_in  = (cnt_rdata != '0) ? cnt_rdata - KW'(1) : cnt_rdata;
      wdec_in = map_rdata;
      wdec_in[ov_ff[WL-1:0]] = (dec_in == '0);
   end

   always_comb begin
      fw_sel = '0;
      for (int i = NW - 1; i >= 0; i--) begin
         if (summary_ff[i]) begin
            fw_sel = NA'(i);
         end
      end
   end

   always_comb begin
      fb = '0;
      for (int j = W - 1; j >= 0; j--) begin
         if (map_rdata[j]) begin
            fb = WL'(j);
         end
      end
   end

   assign mex_full = TA'({fw_ff, fb});

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      summary_in   = summary_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_mex_in   = rsp_mex_ff;
      rsp_all_in   = rsp_all_ff;
      pos_in       = pos_ff;
      pos_ok_in    = pos_ok_ff;
      nv_in        = nv_ff;
      nv_trk_in    = nv_trk_ff;
      ov_in        = ov_ff;
      ov_trk_in    = ov_trk_ff;
      fw_in        = fw_ff;
      found_in     = found_ff;

      ent_we = 1'b0;
      ent_wa = pos_ff;
      ent_wd = nv_ff;
      ent_re = 1'b0;
      ent_ra = EA'(req_position);
      cnt_we = 1'b0;
      cnt_wa = ov_ff;
      cnt_wd = dec_in;
      cnt_re = 1'b0;
      cnt_ra = ov_t;
      map_we = 1'b0;
      map_wa = wo;
      map_wd = wdec_in;
      map_re = 1'b0;
      map_ra = NA'(ov_t >> WL);

      case (state_ff)
         ST_CLEAR: begin
            ent_we = (32'(clr_ff) < ENTRIES);
            ent_wa = EA'(clr_ff);
            ent_wd = UNTRACKED;
            cnt_we = (32'(clr_ff) < TRACKED);
            cnt_wa = TA'(clr_ff);
            cnt_wd = '0;
            map_we = (32'(clr_ff) < NW);
            map_wa = NA'(clr_ff);
            map_wd = (32'(clr_ff) == NW - 1) ? LAST_MASK : {W{1'b1}};
            clr_in = clr_ff + CW'(1);
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               ent_re    = 1'b1;
               pos_in    = EA'(req_position);
               pos_ok_in = ({22'b0, req_position} < 32'(ENTRIES));
               nv_in     = req_new_value;
               nv_trk_in = ({22'b0, req_position} < 32'(ENTRIES))
                           && ({2'b0, req_new_value} < 32'(TRACKED));
               state_in  = ST_OLD;
            end
         end
         ST_OLD: begin
            ent_we    = pos_ok_ff;
            ov_in     = ov_t;
            ov_trk_in = pos_ok_ff && ({2'b0, ent_rdata} < 32'(TRACKED));
            cnt_re    = 1'b1;
            map_re    = 1'b1;
            state_in  = ST_DEC;
         end
         ST_DEC: begin
            cnt_we = ov_trk_ff;
            map_we = ov_trk_ff;
            if (ov_trk_ff) begin
               summary_in[wo] = |wdec_in;
            end
            cnt_re   = 1'b1;
            cnt_ra   = nv_t;
            map_re   = 1'b1;
            map_ra   = wn;
            state_in = ST_INC;
         end
         ST_INC: begin
            cnt_we = nv_trk_ff;
            cnt_wa = nv_t;
            cnt_wd = cnt_inc;
            map_we = nv_trk_ff;
            map_wa = wn;
            map_wd = word_inc;
            if (nv_trk_ff) begin
               summary_in[wn] = |word_inc;
            end
            state_in = ST_FIND;
         end
         ST_FIND: begin
            fw_in    = fw_sel;
            found_in = |summary_ff;
            map_re   = 1'b1;
            map_ra   = fw_sel;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mex_in   = found_ff ? MW'(mex_full) : '0;
               rsp_all_in   = !found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         summary_ff   <= {NW{1'b1}};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         summary_ff   <= summary_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_mex_ff <= rsp_mex_in;
      rsp_all_ff <= rsp_all_in;
      pos_ff     <= pos_in;
      pos_ok_ff  <= pos_ok_in;
      nv_ff      <= nv_in;
      nv_trk_ff  <= nv_trk_in;
      ov_ff      <= ov_in;
      ov_trk_ff  <= ov_trk_in;
      dec_ff     <= dec_in;
      wdec_ff    <= wdec_in;
      fw_ff      <= fw_in;
      found_ff   <= found_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mex         = rsp_mex_ff;
   assign rsp_all_present = rsp_all_ff;

   // Only one item is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("beat accepted while an item is in work");

   // When the result is encoded, the lowest set summary bit points at a bitmap word with an absent value.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && found_ff |-> (map_rdata != '0))
      else $error("summary and absent bitmap disagree");

   // A finished result waits while the output register is still occupied.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && rsp_valid_ff && !rsp_ready |=> (state_ff == ST_OUT))
      else $error("result dropped while output was stalled");

endmodule

`default_nettype wire

@@ design/mtpu_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module mtpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
